### hw/rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared codes, table entry layout and the command/status bundles that join
// the route table controller and datapath.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  // input item kinds
  localparam logic [1:0] MODE_HELLO  = 2'd0;
  localparam logic [1:0] MODE_TABLE  = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  // result actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ANNOUNCE = 3'd1;
  localparam logic [2:0] ACT_DELIVER  = 3'd2;
  localparam logic [2:0] ACT_FORWARD  = 3'd3;
  localparam logic [2:0] ACT_ANSWER   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_LOCAL_ADDR     = 2'd0;
  localparam logic [1:0] CFG_BROADCAST_ADDR = 2'd1;
  localparam logic [1:0] CFG_INF_DISTANCE   = 2'd2;

  localparam logic [7:0]  LOCAL_ADDR_RST     = 8'd0;
  localparam logic [7:0]  BROADCAST_ADDR_RST = 8'd255;
  localparam logic [15:0] INF_DISTANCE_RST   = 16'd16;

  typedef struct packed {
    logic [7:0]  dest;
    logic [7:0]  hop;
    logic [15:0] metric;
  } route_entry_t;

  // which address the scan looks for
  typedef enum logic [1:0] {
    KEY_SRC,
    KEY_DST,
    KEY_TGT,
    KEY_CAND
  } key_sel_e;

  // what the result registers take
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ANNOUNCE,
    RES_DELIVER,
    RES_FOUND,
    RES_MISSED
  } res_sel_e;

  typedef struct packed {
    logic      load;
    logic      cand_hello;
    logic      cand_table;
    logic      scan_start;
    key_sel_e  key_sel;
    logic      scan_next;
    logic      wr_replace;
    logic      wr_append;
    logic      res_en;
    res_sel_e  res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       deliver;
    logic       forward;
    logic       ins_ok;
    logic       scan_end;
    logic       hit;
    logic       full;
    logic       base_ok;
    logic       better;
  } dp_status_t;

endpackage

### hw/rtl/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer for the route table: dispatches an item, walks the table entry by
// entry through read and compare states and picks the table write and result.
// ----------------------------------------------------------------------------
module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       result_valid_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_CHECK    = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_CMP      = 3'd4;

  localparam logic [1:0] PUR_SENDER = 2'd0;
  localparam logic [1:0] PUR_INSERT = 2'd1;
  localparam logic [1:0] PUR_LOOKUP = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] purpose_q, purpose_d;
  logic       valid_q, valid_d;

  always_comb begin
    state_d   = state_q;
    purpose_d = purpose_q;
    valid_d   = 1'b0;
    cmd_o     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (status_i.mode)
          MODE_HELLO: begin
            cmd_o.cand_hello = 1'b1;
            state_d          = ST_CHECK;
          end
          MODE_TABLE: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.key_sel    = KEY_SRC;
            purpose_d        = PUR_SENDER;
            state_d          = ST_READ;
          end
          MODE_DATA: begin
            if (status_i.deliver) begin
              cmd_o.res_en  = 1'b1;
              cmd_o.res_sel = RES_DELIVER;
              valid_d       = 1'b1;
              state_d       = ST_IDLE;
            end else if (status_i.forward) begin
              cmd_o.scan_start = 1'b1;
              cmd_o.key_sel    = KEY_DST;
              purpose_d        = PUR_LOOKUP;
              state_d          = ST_READ;
            end else begin
              cmd_o.res_en  = 1'b1;
              cmd_o.res_sel = RES_NONE;
              valid_d       = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          MODE_LOOKUP: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.key_sel    = KEY_TGT;
            purpose_d        = PUR_LOOKUP;
            state_d          = ST_READ;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      // candidate route is in place: refuse it or search for its destination
      ST_CHECK: begin
        if (status_i.ins_ok) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.key_sel    = KEY_CAND;
          purpose_d        = PUR_INSERT;
          state_d          = ST_READ;
        end else begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_sel = RES_NONE;
          valid_d       = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      ST_READ: begin
        if (status_i.scan_end) begin
          cmd_o.res_en = 1'b1;
          valid_d      = 1'b1;
          state_d      = ST_IDLE;
          if (purpose_q == PUR_LOOKUP) begin
            cmd_o.res_sel = RES_MISSED;
          end else if (purpose_q == PUR_INSERT && !status_i.full) begin
            cmd_o.wr_append = 1'b1;
            cmd_o.res_sel   = RES_ANNOUNCE;
          end else begin
            cmd_o.res_sel = RES_NONE;
          end
        end else begin
          state_d = ST_CMP;
        end
      end

      ST_CMP: begin
        if (!status_i.hit) begin
          cmd_o.scan_next = 1'b1;
          state_d         = ST_READ;
        end else if (purpose_q == PUR_SENDER && status_i.base_ok) begin
          cmd_o.cand_table = 1'b1;
          state_d          = ST_CHECK;
        end else begin
          cmd_o.res_en = 1'b1;
          valid_d      = 1'b1;
          state_d      = ST_IDLE;
          if (purpose_q == PUR_LOOKUP) begin
            cmd_o.res_sel = RES_FOUND;
          end else if (purpose_q == PUR_INSERT && status_i.better) begin
            cmd_o.wr_replace = 1'b1;
            cmd_o.res_sel    = RES_ANNOUNCE;
          end else begin
            cmd_o.res_sel = RES_NONE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      purpose_q <= PUR_LOOKUP;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      purpose_q <= purpose_d;
      valid_q   <= valid_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

endmodule

### hw/rtl/dvrt_datapath.sv
// ----------------------------------------------------------------------------
// dvrt_datapath
// Item and configuration registers, the route table memory with its fill
// count, the scan pointer, the candidate route and the result registers.
// ----------------------------------------------------------------------------
module dvrt_datapath
  import dvrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  src_addr_i,
  input  logic [7:0]  dst_addr_i,
  input  logic [7:0]  next_addr_i,
  input  logic [7:0]  target_addr_i,
  input  logic [15:0] advertised_distance_i,
  output logic [2:0]  action_o,
  output logic [7:0]  route_to_o,
  output logic [7:0]  route_next_o,
  output logic [15:0] route_distance_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // configuration
  logic [7:0]  local_q, bcast_q;
  logic [15:0] inf_q;

  // current item
  logic [1:0]  mode_q;
  logic [7:0]  src_q, dst_q, nxt_q, tgt_q;
  logic [15:0] adv_q;

  // table and scan
  route_entry_t    mem_q [TABLE_DEPTH];
  route_entry_t    rdata_q;
  logic [CW-1:0]   count_q, idx_q;
  logic [7:0]      key_q, key_d;

  // candidate route
  logic [7:0]  cand_dest_q, cand_hop_q;
  logic [16:0] cand_dist_q;

  // result
  logic [2:0]  act_q, act_d, ans_act;
  logic [7:0]  to_q, to_d, next_q, next_d;
  logic [15:0] dist_q, dist_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  route_entry_t    mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= LOCAL_ADDR_RST;
      bcast_q <= BROADCAST_ADDR_RST;
      inf_q   <= INF_DISTANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOCAL_ADDR:     local_q <= cfg_data_i[7:0];
        CFG_BROADCAST_ADDR: bcast_q <= cfg_data_i[7:0];
        CFG_INF_DISTANCE:   inf_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      src_q  <= src_addr_i;
      dst_q  <= dst_addr_i;
      nxt_q  <= next_addr_i;
      tgt_q  <= target_addr_i;
      adv_q  <= advertised_distance_i;
    end
  end

  always_comb begin
    unique case (cmd_i.key_sel)
      KEY_SRC:  key_d = src_q;
      KEY_DST:  key_d = dst_q;
      KEY_TGT:  key_d = tgt_q;
      KEY_CAND: key_d = cand_dest_q;
      default:  key_d = cand_dest_q;
    endcase
  end

  // slots fill in order and are never freed, so the fill count marks used slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.wr_append) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_next) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      key_q <= key_d;
    end
    if (cmd_i.cand_hello) begin
      cand_dest_q <= src_q;
      cand_hop_q  <= src_q;
      cand_dist_q <= 17'd1;
    end else if (cmd_i.cand_table) begin
      cand_dest_q <= tgt_q;
      cand_hop_q  <= src_q;
      cand_dist_q <= {9'd0, rdata_q.metric[7:0]} + {1'b0, adv_q};
    end
  end

  assign mem_we    = cmd_i.wr_append || cmd_i.wr_replace;
  assign mem_waddr = cmd_i.wr_append ? count_q[AW-1:0] : idx_q[AW-1:0];
  assign mem_wdata = '{dest: cand_dest_q, hop: cand_hop_q, metric: cand_dist_q[15:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[idx_q[AW-1:0]];
  end

  assign status_o.mode     = mode_q;
  assign status_o.deliver  = (dst_q == local_q) || (dst_q == bcast_q);
  assign status_o.forward  = (nxt_q == local_q);
  assign status_o.ins_ok   = (cand_dist_q < {1'b0, inf_q}) && (cand_dest_q != local_q)
                             && (cand_hop_q != local_q);
  assign status_o.scan_end = (idx_q == count_q);
  assign status_o.hit      = (rdata_q.dest == key_q);
  assign status_o.full     = (count_q == FULL_COUNT);
  assign status_o.base_ok  = (rdata_q.metric[7:0] != 8'd0)
                             && ({8'd0, rdata_q.metric[7:0]} < inf_q);
  assign status_o.better   = (cand_dist_q < {1'b0, rdata_q.metric})
                             && (rdata_q.hop != cand_hop_q);

  assign ans_act = (mode_q == MODE_DATA) ? ACT_FORWARD : ACT_ANSWER;

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_ANNOUNCE: begin
        act_d  = ACT_ANNOUNCE;
        to_d   = cand_dest_q;
        next_d = cand_hop_q;
        dist_d = cand_dist_q[15:0];
      end
      RES_DELIVER: begin
        act_d  = ACT_DELIVER;
        to_d   = dst_q;
        next_d = 8'd0;
        dist_d = 16'd0;
      end
      RES_FOUND: begin
        act_d  = ans_act;
        to_d   = key_q;
        next_d = rdata_q.hop;
        dist_d = rdata_q.metric;
      end
      RES_MISSED: begin
        act_d  = ans_act;
        to_d   = key_q;
        next_d = 8'd0;
        dist_d = inf_q;
      end
      default: begin
        act_d  = ACT_NONE;
        to_d   = 8'd0;
        next_d = 8'd0;
        dist_d = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      act_q  <= act_d;
      to_q   <= to_d;
      next_q <= next_d;
      dist_q <= dist_d;
    end
  end

  assign action_o         = act_q;
  assign route_to_o       = to_q;
  assign route_next_o     = next_q;
  assign route_distance_o = dist_q;

endmodule

### hw/rtl/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector route table: learns neighbors and advertised routes,
// answers lookups and forwarding decisions, announces new or better routes.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high while busy is low; busy stays high
// until the item is done, and exactly one result follows in the first cycle
// that busy is low again, marked by result_valid_o for a single cycle with no
// stall. The table memory has one read port and is walked one stored route at
// a time, each read and then compared; a table entry runs the sender search
// followed by the destination search, and a delivered or ignored data packet
// is finished at dispatch without a search. Reset empties the table at once.
// Configuration writes are always ready and are to be issued only while the
// block is idle.
// ----------------------------------------------------------------------------
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  src_addr_i,
  input  logic [7:0]  dst_addr_i,
  input  logic [7:0]  next_addr_i,
  input  logic [7:0]  target_addr_i,
  input  logic [15:0] advertised_distance_i,
  output logic        result_valid_o,
  output logic [2:0]  action_o,
  output logic [7:0]  route_to_o,
  output logic [7:0]  route_next_o,
  output logic [15:0] route_distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  ctrl_cmd_t  dp_cmd;
  dp_status_t dp_status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  dvrt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .status_i       (dp_status),
    .cmd_o          (dp_cmd)
  );

  dvrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (dp_cmd),
    .status_o              (dp_status),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .mode_i                (mode_i),
    .src_addr_i            (src_addr_i),
    .dst_addr_i            (dst_addr_i),
    .next_addr_i           (next_addr_i),
    .target_addr_i         (target_addr_i),
    .advertised_distance_i (advertised_distance_i),
    .action_o              (action_o),
    .route_to_o            (route_to_o),
    .route_next_o          (route_next_o),
    .route_distance_o      (route_distance_o)
  );

  // every finished item produces its result strobe
  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("item finished without a result strobe");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $fell(busy))
    else $error("result strobe without a finished item");

  a_no_append_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.wr_append |-> !dp_status.full)
    else $error("route appended to a full table");

  a_announce_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && action_o == ACT_ANNOUNCE) |-> route_distance_o != 16'd0)
    else $error("announced route with zero distance");

endmodule

### test/route_table_checker.sv
// ----------------------------------------------------------------------------
// route_table_checker
// Watches the item, result and register channels of the route table. Keeps
// its own copy of the routes and the registers, works out the reply to every
// item taken and compares each result with the oldest reply still owed.
// ----------------------------------------------------------------------------
module route_table_checker
  import dvrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  src_addr_i,
  input  logic [7:0]  dst_addr_i,
  input  logic [7:0]  next_addr_i,
  input  logic [7:0]  target_addr_i,
  input  logic [15:0] advertised_distance_i,
  input  logic        result_valid_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  route_to_i,
  input  logic [7:0]  route_next_i,
  input  logic [15:0] route_distance_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          owed_count_o,
  output int          compared_count_o
);

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  dest;
    logic [7:0]  hop;
    logic [15:0] metric;
  } route_reply_t;

  route_entry_t routes [TABLE_DEPTH];
  logic [7:0]   own_addr;
  logic [7:0]   bcast_addr;
  logic [15:0]  inf_dist;
  route_reply_t owed_replies [$];
  int           fails;
  int           compared;

  function automatic int find_route(logic [7:0] addr);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (routes[i].metric != 16'd0 && routes[i].dest == addr) return i;
    end
    return -1;
  endfunction

  // store or improve a route; true when it must be announced
  function automatic bit store_route(logic [7:0] dest, logic [7:0] hop,
                                     logic [16:0] metric);
    if (metric >= {1'b0, inf_dist} || dest == own_addr || hop == own_addr) return 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (routes[i].metric == 16'd0) begin
        routes[i] = '{dest, hop, metric[15:0]};
        return 1'b1;
      end
      if (routes[i].dest == dest) begin
        if (metric < {1'b0, routes[i].metric} && routes[i].hop != hop) begin
          routes[i].hop    = hop;
          routes[i].metric = metric[15:0];
          return 1'b1;
        end
        return 1'b0;
      end
    end
    // table full: drop
    return 1'b0;
  endfunction

  function automatic route_reply_t lookup_reply(logic [2:0] act, logic [7:0] addr);
    int k;
    k = find_route(addr);
    if (k >= 0) return '{act, addr, routes[k].hop, routes[k].metric};
    return '{act, addr, 8'd0, inf_dist};
  endfunction

  function automatic route_reply_t predict_reply(logic [1:0] mode, logic [7:0] src,
                                                 logic [7:0] dst, logic [7:0] nxt,
                                                 logic [7:0] tgt, logic [15:0] adv);
    route_reply_t r;
    int           k;
    logic [7:0]   base;
    logic [16:0]  sum;
    r = '0;
    case (mode)
      MODE_HELLO: begin
        if (store_route(src, src, 17'd1)) r = '{ACT_ANNOUNCE, src, src, 16'd1};
      end
      MODE_TABLE: begin
        k = find_route(src);
        if (k >= 0) begin
          // only the low byte of the sender's distance counts
          base = routes[k].metric[7:0];
          if (base != 8'd0 && {8'd0, base} < inf_dist) begin
            sum = {9'd0, base} + {1'b0, adv};
            if (store_route(tgt, src, sum)) r = '{ACT_ANNOUNCE, tgt, src, sum[15:0]};
          end
        end
      end
      MODE_DATA: begin
        if (dst == own_addr || dst == bcast_addr) r = '{ACT_DELIVER, dst, 8'd0, 16'd0};
        else if (nxt == own_addr) r = lookup_reply(ACT_FORWARD, dst);
      end
      default: r = lookup_reply(ACT_ANSWER, tgt);
    endcase
    return r;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) routes[i] = '0;
      own_addr   = LOCAL_ADDR_RST;
      bcast_addr = BROADCAST_ADDR_RST;
      inf_dist   = INF_DISTANCE_RST;
      owed_replies.delete();
      fails    = 0;
      compared = 0;
    end else begin
      // retire the result before taking a new item on the same edge
      if (result_valid_i) begin
        if (owed_replies.size() == 0) begin
          $display("%0t: unexpected result: action %0d to %0d next %0d distance %0d",
                   $time, action_i, route_to_i, route_next_i, route_distance_i);
          fails++;
        end else begin
          want = owed_replies.pop_front();
          compared++;
          check_field("action", want.action, action_i);
          check_field("route_to", want.dest, route_to_i);
          check_field("route_next", want.hop, route_next_i);
          check_field("route_distance", want.metric, route_distance_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LOCAL_ADDR:     own_addr   = cfg_data_i[7:0];
          CFG_BROADCAST_ADDR: bcast_addr = cfg_data_i[7:0];
          CFG_INF_DISTANCE:   inf_dist   = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        owed_replies.push_back(predict_reply(mode_i, src_addr_i, dst_addr_i, next_addr_i,
                                             target_addr_i, advertised_distance_i));
      end
    end
    fail_count_o     = fails;
    owed_count_o     = owed_replies.size();
    compared_count_o = compared;
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the distance-vector route table: a directed opening over the
// special cases, then phases of random hellos, table entries, data packets
// and lookups drawn from a small address pool, each phase under its own
// register setting. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb;
  import dvrt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 178;
  localparam int POOL_SIZE   = 24;

  logic        clk_i                 = 1'b0;
  logic        rst_ni                = 1'b0;
  logic        start_i               = 1'b0;
  logic        busy;
  logic [1:0]  mode_i                = '0;
  logic [7:0]  src_addr_i            = '0;
  logic [7:0]  dst_addr_i            = '0;
  logic [7:0]  next_addr_i           = '0;
  logic [7:0]  target_addr_i         = '0;
  logic [15:0] advertised_distance_i = '0;
  logic        result_valid_o;
  logic [2:0]  action_o;
  logic [7:0]  route_to_o;
  logic [7:0]  route_next_o;
  logic [15:0] route_distance_o;
  logic        cfg_valid_i           = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i           = '0;
  logic [15:0] cfg_data_i            = '0;

  int         fails;
  int         owed;
  int         compared;
  int         stall_cycles = 0;
  int         mode_count [4];
  int         settings = 0;
  bit         allow_idle = 1'b1;
  logic [7:0] cur_local = LOCAL_ADDR_RST;
  logic [7:0] cur_bcast = BROADCAST_ADDR_RST;
  logic [7:0] addr_pool [POOL_SIZE];

  distance_vector_route_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy                  (busy),
    .mode_i                (mode_i),
    .src_addr_i            (src_addr_i),
    .dst_addr_i            (dst_addr_i),
    .next_addr_i           (next_addr_i),
    .target_addr_i         (target_addr_i),
    .advertised_distance_i (advertised_distance_i),
    .result_valid_o        (result_valid_o),
    .action_o              (action_o),
    .route_to_o            (route_to_o),
    .route_next_o          (route_next_o),
    .route_distance_o      (route_distance_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  route_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) table_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_i                (busy),
    .mode_i                (mode_i),
    .src_addr_i            (src_addr_i),
    .dst_addr_i            (dst_addr_i),
    .next_addr_i           (next_addr_i),
    .target_addr_i         (target_addr_i),
    .advertised_distance_i (advertised_distance_i),
    .result_valid_i        (result_valid_o),
    .action_i              (action_o),
    .route_to_i            (route_to_o),
    .route_next_i          (route_next_o),
    .route_distance_i      (route_distance_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .fail_count_o          (fails),
    .owed_count_o          (owed),
    .compared_count_o      (compared)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called right after a rising edge; returns after transfer and any idle gap
  task automatic send_item(logic [1:0] m, logic [7:0] s, logic [7:0] d, logic [7:0] n,
                           logic [7:0] t, logic [15:0] a);
    mode_i                <= m;
    src_addr_i            <= s;
    dst_addr_i            <= d;
    next_addr_i           <= n;
    target_addr_i         <= t;
    advertised_distance_i <= a;
    start_i               <= 1'b1;
    do @(negedge clk_i); while (busy !== 1'b0);
    @(posedge clk_i);
    mode_count[m]++;
    if (allow_idle && $urandom_range(0, 99) < 13) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // drain the block, then write all three registers back to back
  task automatic write_setting(logic [7:0] la, logic [7:0] ba, logic [15:0] inf);
    logic [15:0] words [3];
    logic [1:0]  regs [3];
    words = '{{8'($urandom), la}, {8'($urandom), ba}, inf};
    regs  = '{CFG_LOCAL_ADDR, CFG_BROADCAST_ADDR, CFG_INF_DISTANCE};
    start_i <= 1'b0;
    @(negedge clk_i);
    while (owed != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    for (int r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= words[r];
      do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_local = la;
    cur_bcast = ba;
    settings++;
  endtask

  function automatic logic [7:0] pick_addr();
    if ($urandom_range(0, 99) < 6) return 8'($urandom);
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [15:0] pick_distance();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 16'($urandom_range(0, 12));
    if (roll < 90) return 16'($urandom_range(0, 300));
    if (roll < 95) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_item();
    logic [1:0] m;
    logic [7:0] d;
    logic [7:0] n;
    if ($urandom_range(0, 99) < 8) begin
      // noise: every field free
      send_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom));
    end else begin
      m = 2'($urandom_range(0, 3));
      d = pick_addr();
      case ($urandom_range(0, 19))
        0, 1:    d = cur_local;
        2:       d = cur_bcast;
        default: ;
      endcase
      n = ($urandom_range(0, 99) < 60) ? cur_local : pick_addr();
      send_item(m, pick_addr(), d, n, pick_addr(), pick_distance());
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) mode_count[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: local 0, broadcast 255, unreachable at 16
    send_item(MODE_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 16'($urandom));
    send_item(MODE_HELLO, 8'd0, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    send_item(MODE_HELLO, 8'd1, 8'd0, 8'd0, 8'd0, 16'd0);
    send_item(MODE_HELLO, 8'd1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(MODE_HELLO, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    send_item(MODE_TABLE, 8'd1, 8'($urandom), 8'($urandom), 8'd2, 16'd3);
    // shorter but same hop: keep the old route
    send_item(MODE_TABLE, 8'd1, 8'($urandom), 8'($urandom), 8'd2, 16'd1);
    // shorter through another hop: replace
    send_item(MODE_TABLE, 8'd255, 8'($urandom), 8'($urandom), 8'd2, 16'd0);
    send_item(MODE_TABLE, 8'd1, 8'($urandom), 8'($urandom), 8'd3, 16'd15);
    send_item(MODE_TABLE, 8'd1, 8'($urandom), 8'($urandom), 8'd3, 16'hFFFF);
    send_item(MODE_TABLE, 8'd9, 8'($urandom), 8'($urandom), 8'd3, 16'd1);
    send_item(MODE_TABLE, 8'd1, 8'($urandom), 8'($urandom), 8'd0, 16'd2);
    send_item(MODE_TABLE, 8'd1, 8'($urandom), 8'($urandom), 8'd4, 16'd14);
    send_item(MODE_HELLO, 8'd4, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    send_item(MODE_DATA, 8'($urandom), 8'd0, 8'd7, 8'($urandom), 16'($urandom));
    send_item(MODE_DATA, 8'($urandom), 8'd255, 8'd0, 8'($urandom), 16'($urandom));
    send_item(MODE_DATA, 8'($urandom), 8'd2, 8'd0, 8'($urandom), 16'($urandom));
    send_item(MODE_DATA, 8'($urandom), 8'd77, 8'd0, 8'($urandom), 16'($urandom));
    send_item(MODE_DATA, 8'($urandom), 8'd2, 8'd255, 8'($urandom), 16'($urandom));
    send_item(MODE_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255, 16'($urandom));
    send_item(MODE_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'd2, 16'($urandom));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_setting(8'd0, 8'd255, 16'd16);
        1: write_setting(8'd255, 8'd0, 16'hFFFF);
        2: write_setting(addr_pool[3], addr_pool[5], 16'd1);
        3: write_setting(8'($urandom), 8'd255, 16'd200);
        4: write_setting(8'd0, 8'($urandom), 16'd0);
        5: write_setting(addr_pool[0], 8'd255, 16'd40);
        6: write_setting(8'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)));
        default: write_setting(8'h5A, 8'hA5, 16'd16);
      endcase
      // one phase runs back to back
      allow_idle = (p != 3);
      repeat (PHASE_ITEMS) random_item();
    end

    start_i <= 1'b0;
    @(negedge clk_i);
    while (owed != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    $display("Covered %0d hellos, %0d table entries, %0d data packets, %0d lookups",
             mode_count[MODE_HELLO], mode_count[MODE_TABLE], mode_count[MODE_DATA],
             mode_count[MODE_LOOKUP]);
    $display("under %0d register settings; %0d results compared", settings, compared);
    if (owed != 0) $display("%0t: %0d results never arrived", $time, owed);
    if (fails == 0 && owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
